### rtl/vt4_pkg.sv
package vt4_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned DIM           = 4;
  localparam int unsigned NUM_COEFF     = DIM * DIM;

  // command codes carried in the cmd field
  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_XFORM4 = 2'd1;
  localparam logic [1:0] CMD_XFORM3 = 2'd2;

  typedef logic signed [31:0] word_t;
  typedef logic signed [63:0] prod_t;
  typedef logic signed [64:0] pair_t;
  typedef logic signed [65:0] sum_t;

  // per-stage load enables shared by the lanes and the merge stage
  typedef struct packed {
    logic en1;
    logic en2;
    logic en3;
    logic en_out;
  } pipe_ctrl_t;

endpackage

### rtl/vt4_if.sv
interface vt4_in_if;
  logic                 valid;
  logic                 ready;
  logic [1:0]           cmd;
  logic [3:0]           coeff_index;
  logic signed [31:0]   coeff_value;
  logic signed [31:0]   vec_x;
  logic signed [31:0]   vec_y;
  logic signed [31:0]   vec_z;
  logic signed [31:0]   vec_w;

  modport source (output valid, cmd, coeff_index, coeff_value, vec_x, vec_y, vec_z, vec_w,
                  input ready);
  modport sink   (input valid, cmd, coeff_index, coeff_value, vec_x, vec_y, vec_z, vec_w,
                  output ready);
endinterface

interface vt4_out_if;
  logic                 valid;
  logic                 ready;
  logic signed [31:0]   out_x;
  logic signed [31:0]   out_y;
  logic signed [31:0]   out_z;
  logic signed [31:0]   out_w;
  logic                 saturated;

  modport source (output valid, out_x, out_y, out_z, out_w, saturated, input ready);
  modport sink   (input valid, out_x, out_y, out_z, out_w, saturated, output ready);
endinterface

### rtl/vertex_transform_4x4_top.sv
// Channel   Dir  Modport           Payload
// vtx_i     in   vt4_in_if.sink    cmd, coeff_index, coeff_value, vec_x..vec_w
// res_o     out  vt4_out_if.source out_x, out_y, out_z, out_w, saturated
//
// One transaction per cycle sustained while res_o is not stalled. A transform
// result goes through multiply (loaded at acceptance), pair add, row add, then
// scale/clip into the output register.
// A load updates the matrix at its accept edge and produces no result.
// Reset (rst_ni low, async) sets the matrix to identity and empties the pipeline.
// A stalled output backs up one stage at a time; bubbles are squeezed out, so
// input keeps being taken until every stage holds a transaction.
module vertex_transform_4x4_top #(
  parameter int unsigned FRAC_BITS = vt4_pkg::FRAC_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  vt4_in_if.sink       vtx_i,
  vt4_out_if.source    res_o
);
  import vt4_pkg::*;

  localparam word_t ONE = word_t'(32'sd1 <<< FRAC_BITS);

  // coefficient matrix, row-major, flops so each lane reads its row directly
  word_t [NUM_COEFF-1:0] coeff_q;

  logic       v1_q, v2_q, v3_q, ov_q;
  pipe_ctrl_t ctrl;
  logic       in_fire;
  logic       is_xform;
  logic       is_x4;

  word_t [DIM-1:0] vec;
  word_t [DIM-1:0] lane_res;
  logic  [DIM-1:0] lane_sat;
  word_t [DIM-1:0] out_res;

  // stage enables: a stage loads when it is empty or its successor moves
  always_comb begin
    ctrl.en_out = !ov_q || res_o.ready;
    ctrl.en3    = !v3_q || ctrl.en_out;
    ctrl.en2    = !v2_q || ctrl.en3;
    ctrl.en1    = !v1_q || ctrl.en2;
  end

  assign vtx_i.ready = ctrl.en1;
  assign in_fire     = vtx_i.valid && vtx_i.ready;
  assign is_x4       = vtx_i.cmd == CMD_XFORM4;
  assign is_xform    = is_x4 || (vtx_i.cmd == CMD_XFORM3);

  // w drops out of the three-component transform
  assign vec[0] = vtx_i.vec_x;
  assign vec[1] = vtx_i.vec_y;
  assign vec[2] = vtx_i.vec_z;
  assign vec[3] = is_x4 ? vtx_i.vec_w : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_COEFF; i++) begin
        coeff_q[i] <= ((i % (DIM + 1)) == 0) ? ONE : '0;
      end
    end else if (in_fire && (vtx_i.cmd == CMD_LOAD)) begin
      coeff_q[vtx_i.coeff_index] <= vtx_i.coeff_value;
    end
  end

  // valid bits per stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      if (ctrl.en1)    v1_q <= in_fire && is_xform;
      if (ctrl.en2)    v2_q <= v1_q;
      if (ctrl.en3)    v3_q <= v2_q;
      if (ctrl.en_out) ov_q <= v3_q;
    end
  end

  // four row lanes; the bottom row is idle for a three-component transform
  for (genvar r = 0; r < DIM; r++) begin : g_lane
    vt4_lane #(
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk_i    (clk_i),
      .ctrl_i   (ctrl),
      .row_en_i ((r < DIM - 1) || is_x4),
      .coeff_i  (coeff_q[r*DIM +: DIM]),
      .vec_i    (vec),
      .res_o    (lane_res[r]),
      .sat_o    (lane_sat[r])
    );
  end

  vt4_merge u_merge (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .res_i  (lane_res),
    .sat_i  (lane_sat),
    .res_o  (out_res),
    .sat_o  (res_o.saturated)
  );

  assign res_o.valid = ov_q;
  assign res_o.out_x = out_res[0];
  assign res_o.out_y = out_res[1];
  assign res_o.out_z = out_res[2];
  assign res_o.out_w = out_res[3];

  // a result only appears from a filled last stage
  a_out_from_s3: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ov_q) |-> $past(v3_q))
    else $error("output valid without a transaction in stage 3");

  // an accepted transform always enters stage 1
  a_xform_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && is_xform) |=> v1_q)
    else $error("accepted transform lost at stage 1");

  // a stalled stage 3 keeps its transaction
  a_s3_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && !ctrl.en3) |=> v3_q)
    else $error("stage 3 transaction dropped during stall");

  // a load lands in the addressed coefficient
  a_load_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (vtx_i.cmd == CMD_LOAD))
      |=> coeff_q[$past(vtx_i.coeff_index)] == $past(vtx_i.coeff_value))
    else $error("coefficient load not stored");

endmodule

### rtl/vt4_lane.sv
module vt4_lane #(
  parameter int unsigned FRAC_BITS = vt4_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  vt4_pkg::pipe_ctrl_t                 ctrl_i,
  input  logic                                row_en_i,
  input  vt4_pkg::word_t [vt4_pkg::DIM-1:0]   coeff_i,
  input  vt4_pkg::word_t [vt4_pkg::DIM-1:0]   vec_i,
  output vt4_pkg::word_t                      res_o,
  output logic                                sat_o
);
  import vt4_pkg::*;

  localparam sum_t SAT_MAX = sum_t'(64'sh0000_0000_7FFF_FFFF);
  localparam sum_t SAT_MIN = -sum_t'(64'sh0000_0000_8000_0000);

  prod_t [DIM-1:0] prod_d, prod_q;
  pair_t [1:0]     pair_d, pair_q;
  sum_t            sum_d, sum_q;
  sum_t            shifted;

  // stage 1: one 32x32 multiply per column, operands sign-extended to the product width
  always_comb begin
    for (int k = 0; k < DIM; k++) begin
      prod_d[k] = row_en_i ? prod_t'(coeff_i[k]) * prod_t'(vec_i[k]) : '0;
    end
  end

  // stage 2: pairwise sums
  assign pair_d[0] = pair_t'($signed(prod_q[0])) + pair_t'($signed(prod_q[1]));
  assign pair_d[1] = pair_t'($signed(prod_q[2])) + pair_t'($signed(prod_q[3]));

  // stage 3: exact row sum
  assign sum_d = sum_t'($signed(pair_q[0])) + sum_t'($signed(pair_q[1]));

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en1) prod_q <= prod_d;
    if (ctrl_i.en2) pair_q <= pair_d;
    if (ctrl_i.en3) sum_q  <= sum_d;
  end

  // floor scaling, then clip to 32 bits
  always_comb begin
    shifted = sum_q >>> FRAC_BITS;
    sat_o   = 1'b0;
    if (shifted > SAT_MAX) begin
      res_o = word_t'(32'sh7FFF_FFFF);
      sat_o = 1'b1;
    end else if (shifted < SAT_MIN) begin
      res_o = word_t'(32'sh8000_0000);
      sat_o = 1'b1;
    end else begin
      res_o = word_t'(shifted[31:0]);
    end
  end

endmodule

### rtl/vt4_merge.sv
module vt4_merge (
  input  logic                                clk_i,
  input  vt4_pkg::pipe_ctrl_t                 ctrl_i,
  input  vt4_pkg::word_t [vt4_pkg::DIM-1:0]   res_i,
  input  logic [vt4_pkg::DIM-1:0]             sat_i,
  output vt4_pkg::word_t [vt4_pkg::DIM-1:0]   res_o,
  output logic                                sat_o
);
  import vt4_pkg::*;

  word_t [DIM-1:0] res_q;
  logic            sat_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en_out) begin
      res_q <= res_i;
      sat_q <= |sat_i;
    end
  end

  assign res_o = res_q;
  assign sat_o = sat_q;

endmodule

### dv/vertex_transform_4x4_top_tb.sv
module vertex_transform_4x4_top_tb;
  import vt4_pkg::*;

  localparam int unsigned FRAC = FRAC_BITS_DEF;
  // cmd value 3 has no meaning; the block must drop it silently
  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam word_t ONE_Q = word_t'(1 << FRAC);
  localparam word_t MAX_Q = 32'sh7fffffff;
  localparam word_t MIN_Q = 32'sh80000000;

  // one input transaction as queued for the driver
  typedef struct packed {
    logic [1:0] cmd;
    logic [3:0] coeff_index;
    word_t      coeff_value;
    word_t      x;
    word_t      y;
    word_t      z;
    word_t      w;
  } vtx_item_t;

  // one transform result; comp[0..3] is x, y, z, w
  typedef struct packed {
    word_t [3:0] comp;
    logic        sat;
  } xform_res_t;

  logic clk_i = 1'b0;
  logic rst_n;

  vt4_in_if  vtx_if ();
  vt4_out_if res_if ();

  vertex_transform_4x4_top #(
    .FRAC_BITS(FRAC)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_n),
    .vtx_i (vtx_if),
    .res_o (res_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor state: our own copy of the coefficient matrix, updated in
  // acceptance order, plus the queue of transform results still owed.
  // --------------------------------------------------------------------------
  word_t      coeff_mat [NUM_COEFF];
  vtx_item_t  pending_vtx_q [$];
  xform_res_t owed_xform_q [$];
  vtx_item_t  cur_vtx;
  logic       vtx_taken = 1'b0;
  int         queued_cnt = 0;
  int         accepted_cnt = 0;
  int         err_cnt = 0;
  int         src_idle_pct = 0;
  int         snk_stall_pct = 0;

  // Exact dot product per row: 66 bits holds four 32x32 products with room.
  // The arithmetic shift floors toward minus infinity, then clip to 32 bits.
  function automatic xform_res_t transform_vertex(vtx_item_t it);
    logic signed [65:0] vec [4];
    logic signed [65:0] coef;
    logic signed [65:0] acc;
    int                 n;
    xform_res_t         r;
    vec[0] = 66'(it.x);
    vec[1] = 66'(it.y);
    vec[2] = 66'(it.z);
    vec[3] = 66'(it.w);
    n = (it.cmd == CMD_XFORM4) ? 4 : 3;
    r = '0;
    for (int row = 0; row < n; row++) begin
      acc = '0;
      for (int k = 0; k < n; k++) begin
        coef = 66'(coeff_mat[row * 4 + k]);
        acc  = acc + coef * vec[k];
      end
      acc = acc >>> FRAC;
      if (acc > 66'sd2147483647) begin
        r.comp[row] = MAX_Q;
        r.sat       = 1'b1;
      end else if (acc < -66'sd2147483648) begin
        r.comp[row] = MIN_Q;
        r.sat       = 1'b1;
      end else begin
        r.comp[row] = acc[31:0];
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (err_cnt < 40) begin
      $display("%0t ERROR %s", $time, msg);
    end
    err_cnt++;
  endtask

  // --------------------------------------------------------------------------
  // Driver: everything changes on the falling edge. A held transaction stays
  // on the bus until it is taken; the next one may follow back to back.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_n) begin
      vtx_if.valid <= 1'b0;
    end else if (!vtx_if.valid || vtx_taken) begin
      if (pending_vtx_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        cur_vtx = pending_vtx_q.pop_front();
        vtx_if.valid       <= 1'b1;
        vtx_if.cmd         <= cur_vtx.cmd;
        vtx_if.coeff_index <= cur_vtx.coeff_index;
        vtx_if.coeff_value <= cur_vtx.coeff_value;
        vtx_if.vec_x       <= cur_vtx.x;
        vtx_if.vec_y       <= cur_vtx.y;
        vtx_if.vec_z       <= cur_vtx.z;
        vtx_if.vec_w       <= cur_vtx.w;
      end else begin
        vtx_if.valid <= 1'b0;
      end
    end
    res_if.ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  // --------------------------------------------------------------------------
  // Monitor: sample on the rising edge. Results are checked against the
  // oldest owed transform; accepted inputs feed the predictor.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_n && res_if.valid && res_if.ready) begin
      if (owed_xform_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing owed: %h %h %h %h sat %b",
                                  res_if.out_x, res_if.out_y, res_if.out_z,
                                  res_if.out_w, res_if.saturated));
      end else begin
        xform_res_t exp_r;
        word_t      got_c [4];
        exp_r = owed_xform_q.pop_front();
        got_c[0] = res_if.out_x;
        got_c[1] = res_if.out_y;
        got_c[2] = res_if.out_z;
        got_c[3] = res_if.out_w;
        for (int k = 0; k < 4; k++) begin
          if (got_c[k] !== exp_r.comp[k]) begin
            report_mismatch($sformatf("component %0d got %h expected %h",
                                      k, got_c[k], exp_r.comp[k]));
          end
        end
        if (res_if.saturated !== exp_r.sat) begin
          report_mismatch($sformatf("saturated got %b expected %b",
                                    res_if.saturated, exp_r.sat));
        end
      end
    end
    if (rst_n && vtx_if.valid && vtx_if.ready) begin
      vtx_taken <= 1'b1;
      accepted_cnt++;
      case (cur_vtx.cmd)
        CMD_LOAD:               coeff_mat[cur_vtx.coeff_index] = cur_vtx.coeff_value;
        CMD_XFORM4, CMD_XFORM3: owed_xform_q.push_back(transform_vertex(cur_vtx));
        default: ;
      endcase
    end else begin
      vtx_taken <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic queue_vtx(input logic [1:0] cmd, input logic [3:0] idx, input word_t cv,
                           input word_t x, input word_t y, input word_t z, input word_t w);
    pending_vtx_q.push_back(vtx_item_t'{cmd, idx, cv, x, y, z, w});
    queued_cnt++;
  endtask

  // vector components: extremes, full range and values of everyday size
  function automatic word_t rand_vec_word();
    case ($urandom_range(9))
      0:       return MAX_Q;
      1:       return MIN_Q;
      2:       return '0;
      3, 4, 5: return word_t'($urandom);
      default: return word_t'($urandom_range(32'h1fffff)) - 32'sd1048576;
    endcase
  endfunction

  // coefficients: mostly within +-2.0 so results stay in range, some wild
  function automatic word_t rand_coeff();
    case ($urandom_range(9))
      0:       return ONE_Q;
      1:       return -ONE_Q;
      2:       return '0;
      3:       return word_t'($urandom);
      4:       return $urandom_range(1) ? MAX_Q : MIN_Q;
      default: return word_t'($urandom_range(32'h3ffff)) - 32'sd131072;
    endcase
  endfunction

  task automatic queue_rand_xform();
    queue_vtx($urandom_range(1) ? CMD_XFORM4 : CMD_XFORM3, 4'($urandom),
              word_t'($urandom), rand_vec_word(), rand_vec_word(), rand_vec_word(),
              rand_vec_word());
  endtask

  // Well-formed bursts: rewrite a few coefficients, then run vertices through.
  // About one burst in ten is noise: unused commands or a bare transform.
  task automatic queue_random(input int n);
    int made;
    made = 0;
    while (made < n) begin
      if ($urandom_range(9) == 0) begin
        if ($urandom_range(1)) begin
          queue_vtx(CMD_NONE, 4'($urandom), word_t'($urandom), word_t'($urandom),
                    word_t'($urandom), word_t'($urandom), word_t'($urandom));
        end else begin
          queue_rand_xform();
          made++;
        end
      end else begin
        repeat ($urandom_range(5)) begin
          queue_vtx(CMD_LOAD, 4'($urandom), rand_coeff(), word_t'($urandom),
                    word_t'($urandom), word_t'($urandom), word_t'($urandom));
          made++;
        end
        repeat ($urandom_range(1, 6)) begin
          queue_rand_xform();
          made++;
        end
      end
    end
  endtask

  // Hold the sender off until every queued transaction is taken and every
  // owed result is back.
  task automatic wait_drained();
    while (accepted_cnt != queued_cnt || owed_xform_q.size() != 0) begin
      @(negedge clk_i);
    end
    @(posedge clk_i);
  endtask

  task automatic queue_directed();
    // identity matrix straight out of reset
    queue_vtx(CMD_XFORM4, 4'd0, '0, ONE_Q, ONE_Q * 2, -ONE_Q * 3, ONE_Q);
    queue_vtx(CMD_XFORM4, 4'hf, MAX_Q, MAX_Q, MIN_Q, '0, -32'sd1);
    // three-component form must zero out_w whatever vec_w holds
    queue_vtx(CMD_XFORM3, 4'ha, MIN_Q, -ONE_Q, MAX_Q, 32'sd12345, MIN_Q);
    // unused command, all fields set: no state change, no result
    queue_vtx(CMD_NONE, 4'hf, MAX_Q, MAX_Q, MAX_Q, MAX_Q, MAX_Q);
    queue_vtx(CMD_NONE, 4'd0, '0, MIN_Q, MIN_Q, MIN_Q, MIN_Q);
    // translation column: used by four-component, skipped by three
    queue_vtx(CMD_LOAD, 4'd3, ONE_Q * 10, MAX_Q, MAX_Q, MAX_Q, MAX_Q);
    queue_vtx(CMD_LOAD, 4'd7, -ONE_Q * 5, MIN_Q, MIN_Q, MIN_Q, MIN_Q);
    queue_vtx(CMD_LOAD, 4'd11, ONE_Q / 2, '0, '0, '0, '0);
    queue_vtx(CMD_XFORM4, 4'd3, MAX_Q, ONE_Q, ONE_Q, ONE_Q, ONE_Q);
    queue_vtx(CMD_XFORM3, 4'd7, MIN_Q, ONE_Q, ONE_Q, ONE_Q, ONE_Q);
    // bottom row at the extremes: w clips, the three-component form ignores it
    queue_vtx(CMD_LOAD, 4'd15, MAX_Q, '0, '0, '0, '0);
    queue_vtx(CMD_LOAD, 4'd12, MIN_Q, '0, '0, '0, '0);
    queue_vtx(CMD_XFORM4, 4'd0, '0, MIN_Q, ONE_Q, ONE_Q, MAX_Q);
    queue_vtx(CMD_XFORM3, 4'd0, '0, MIN_Q, ONE_Q, ONE_Q, MAX_Q);
    // x row at full scale: clip high and clip low
    queue_vtx(CMD_LOAD, 4'd0, MAX_Q, '0, '0, '0, '0);
    queue_vtx(CMD_XFORM3, 4'd0, '0, MAX_Q, '0, '0, '0);
    queue_vtx(CMD_XFORM3, 4'd0, '0, MIN_Q, '0, '0, '0);
    // negative small sums floor toward minus infinity
    queue_vtx(CMD_LOAD, 4'd5, -32'sd1, '0, '0, '0, '0);
    queue_vtx(CMD_XFORM4, 4'd0, '0, '0, 32'sd1, 32'sd3, -32'sd1);
    queue_vtx(CMD_LOAD, 4'd0, ONE_Q, '0, '0, '0, '0);
    queue_vtx(CMD_XFORM4, 4'd0, '0, -32'sd1, MIN_Q, MIN_Q, MIN_Q);
  endtask

  // --------------------------------------------------------------------------
  // Run: reset once, then four traffic phases. Each phase drains midway and
  // at its end, so the sender sits idle until every result is back.
  // --------------------------------------------------------------------------
  initial begin
    rst_n              = 1'b0;
    vtx_if.valid       = 1'b0;
    vtx_if.cmd         = CMD_LOAD;
    vtx_if.coeff_index = '0;
    vtx_if.coeff_value = '0;
    vtx_if.vec_x       = '0;
    vtx_if.vec_y       = '0;
    vtx_if.vec_z       = '0;
    vtx_if.vec_w       = '0;
    res_if.ready       = 1'b0;
    for (int i = 0; i < NUM_COEFF; i++) begin
      coeff_mat[i] = (i % 5 == 0) ? ONE_Q : '0;
    end
    repeat (8) @(negedge clk_i);
    rst_n <= 1'b1;
    for (int ph = 0; ph < 4; ph++) begin
      @(posedge clk_i);
      case (ph)
        0: begin
          src_idle_pct  = 0;
          snk_stall_pct = 0;
        end
        1: begin
          src_idle_pct  = 63;
          snk_stall_pct = 0;
        end
        2: begin
          src_idle_pct  = 0;
          snk_stall_pct = 63;
        end
        default: begin
          src_idle_pct  = 13;
          snk_stall_pct = 13;
        end
      endcase
      if (ph == 0) begin
        queue_directed();
      end
      queue_random(225);
      wait_drained();
      queue_random(225);
      wait_drained();
    end
    // leave room for any stray late transaction
    repeat (12) @(negedge clk_i);
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // hang guard
  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### sim.f
rtl/vt4_pkg.sv
rtl/vt4_if.sv
rtl/vt4_lane.sv
rtl/vt4_merge.sv
rtl/vertex_transform_4x4_top.sv
dv/vertex_transform_4x4_top_tb.sv
